// ===== rtl/mtp_pkg.sv =====
package mtp_pkg;

    // Character codes recognized by the parser
    localparam logic [7:0] CHAR_TERM   = 8'h00;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    // Hex digit value offset for letters
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    // Output address width
    localparam int MAC_W = 48;

    // Classification of one character
    typedef struct packed {
        logic       is_term;
        logic       is_colon;
        logic       is_digit;
        logic [3:0] digit;
    } t_char_class;

endpackage

// ===== rtl/mtp_char_decode.sv =====
module mtp_char_decode (
    input  logic [7:0]          i_character,
    output mtp_pkg::t_char_class o_class
);

    logic [7:0] w_num;
    logic [7:0] w_upper;
    logic [7:0] w_lower;

    assign w_num   = i_character - mtp_pkg::CHAR_ZERO;
    assign w_upper = i_character - mtp_pkg::CHAR_UPPER_A + mtp_pkg::HEX_LETTER_BASE;
    assign w_lower = i_character - mtp_pkg::CHAR_LOWER_A + mtp_pkg::HEX_LETTER_BASE;

    // Classify the character and decode its hex value, case-insensitive
    always_comb begin
        o_class          = '0;
        o_class.is_term  = (i_character == mtp_pkg::CHAR_TERM);
        o_class.is_colon = (i_character == mtp_pkg::CHAR_COLON);
        if (i_character >= mtp_pkg::CHAR_ZERO && i_character <= mtp_pkg::CHAR_NINE) begin
            o_class.is_digit = 1'b1;
            o_class.digit    = w_num[3:0];
        end else if (i_character >= mtp_pkg::CHAR_UPPER_A &&
                     i_character <= mtp_pkg::CHAR_UPPER_F) begin
            o_class.is_digit = 1'b1;
            o_class.digit    = w_upper[3:0];
        end else if (i_character >= mtp_pkg::CHAR_LOWER_A &&
                     i_character <= mtp_pkg::CHAR_LOWER_F) begin
            o_class.is_digit = 1'b1;
            o_class.digit    = w_lower[3:0];
        end
    end

endmodule

// ===== rtl/mac_address_text_parser.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------
// input    | in        | i_valid / o_stall  | i_character[7:0]
// result   | out       | o_valid / i_stall  | o_mac_address[47:0], o_status
//
// One character is taken per cycle while o_stall is low; the parse state updates at acceptance.
// An accepted terminator loads the result register and clears the parse state.
// Input stalls only while a result is held and the result side stalls.
// Synchronous active-low reset clears the parse state and the result valid.
module mac_address_text_parser #(
    parameter int NUM_BYTES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_mac_address,
    output logic        o_status
);

    localparam int IDX_W = $clog2(NUM_BYTES + 1);
    localparam int ACC_W = 8 * NUM_BYTES;
    localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(NUM_BYTES);

    mtp_pkg::t_char_class w_class;

    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [1:0]       r_digit_count, n_digit_count;
    logic             r_sep_allowed, n_sep_allowed;
    logic [7:0]       r_partial, n_partial;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_error, n_error;

    logic             r_out_valid;
    logic [47:0]      r_out_mac;
    logic             r_out_status;

    logic             w_accept;
    logic             w_store;
    logic [7:0]       w_store_byte;
    logic [7:0]       w_shifted;
    logic [ACC_W-1:0] w_acc_stored;
    logic [47:0]      w_acc_mac;

    mtp_char_decode u_decode (
        .i_character (i_character),
        .o_class     (w_class)
    );

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_shifted = {r_partial[3:0], w_class.digit};

    // Decide whether this request completes a byte, and which value it stores
    always_comb begin
        w_store      = 1'b0;
        w_store_byte = r_partial;
        if (w_class.is_term) begin
            w_store = !r_error && (r_byte_index < IDX_FULL);
        end else if (!r_error && (r_byte_index < IDX_FULL)) begin
            if (w_class.is_digit) begin
                w_store      = (r_digit_count != 2'd0);
                w_store_byte = w_shifted;
            end else if (w_class.is_colon) begin
                w_store = r_sep_allowed || (r_digit_count != 2'd0);
            end
        end
    end

    // Place the finished byte into its lane of the accumulator
    always_comb begin
        w_acc_stored = r_acc;
        for (int i = 0; i < NUM_BYTES; i++) begin
            if (r_byte_index == IDX_W'(i)) begin
                w_acc_stored[8*(NUM_BYTES-1-i) +: 8] = r_acc[8*(NUM_BYTES-1-i) +: 8] |
                                                       w_store_byte;
            end
        end
    end

    // Fit the accumulator to the address width
    generate
        if (ACC_W >= mtp_pkg::MAC_W) begin : g_trim
            assign w_acc_mac = w_acc_stored[mtp_pkg::MAC_W-1:0];
        end else begin : g_pad
            assign w_acc_mac = {{(mtp_pkg::MAC_W-ACC_W){1'b0}}, w_acc_stored};
        end
    endgenerate

    // Next parse state
    always_comb begin
        n_byte_index  = r_byte_index;
        n_digit_count = r_digit_count;
        n_sep_allowed = r_sep_allowed;
        n_partial     = r_partial;
        n_acc         = r_acc;
        n_error       = r_error;
        if (w_class.is_term) begin
            n_byte_index  = '0;
            n_digit_count = '0;
            n_sep_allowed = 1'b1;
            n_partial     = '0;
            n_acc         = '0;
            n_error       = 1'b0;
        end else if (!r_error) begin
            if (r_byte_index >= IDX_FULL) begin
                n_error = 1'b1;
            end else if (w_class.is_digit) begin
                n_partial     = w_shifted;
                n_digit_count = r_digit_count + 2'd1;
                n_sep_allowed = 1'b1;
                if (w_store) begin
                    n_sep_allowed = 1'b0;
                end
            end else if (w_class.is_colon) begin
                n_sep_allowed = 1'b1;
            end else begin
                n_error = 1'b1;
            end
            if (w_store) begin
                n_acc         = w_acc_stored;
                n_byte_index  = r_byte_index + IDX_W'(1);
                n_digit_count = '0;
                n_partial     = '0;
            end
        end
    end

    // Hold the parse state, advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index  <= '0;
            r_digit_count <= '0;
            r_sep_allowed <= 1'b1;
            r_partial     <= '0;
            r_acc         <= '0;
            r_error       <= 1'b0;
        end else if (w_accept) begin
            r_byte_index  <= n_byte_index;
            r_digit_count <= n_digit_count;
            r_sep_allowed <= n_sep_allowed;
            r_partial     <= n_partial;
            r_acc         <= n_acc;
            r_error       <= n_error;
        end
    end

    // Load the result on a terminator, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_class.is_term) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_class.is_term) begin
            r_out_mac    <= r_error ? '0 : w_acc_mac;
            r_out_status <= r_error;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_mac_address = r_out_mac;
    assign o_status      = r_out_status;

endmodule
